// ===== hw/rtl/cts_pkg.sv =====
package cts_pkg;

  // Table size and dispatch limit
  localparam int CTS_MAX_TASKS    = 8;
  localparam int CTS_RESULT_LIMIT = 8;

  // Command codes
  localparam logic [2:0] CMD_INIT     = 3'd0;
  localparam logic [2:0] CMD_ADD      = 3'd1;
  localparam logic [2:0] CMD_TICK     = 3'd2;
  localparam logic [2:0] CMD_DISPATCH = 3'd3;
  localparam logic [2:0] CMD_DELETE   = 3'd4;

  // Result kinds
  localparam logic [2:0] KIND_INIT_DONE  = 3'd0;
  localparam logic [2:0] KIND_ADDED      = 3'd1;
  localparam logic [2:0] KIND_FULL       = 3'd2;
  localparam logic [2:0] KIND_TICK_DONE  = 3'd3;
  localparam logic [2:0] KIND_DUE        = 3'd4;
  localparam logic [2:0] KIND_NONE_DUE   = 3'd5;
  localparam logic [2:0] KIND_DELETED    = 3'd6;
  localparam logic [2:0] KIND_DEL_REJECT = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] task_handle;
    logic [31:0] delay_ticks;
    logic [31:0] period_ticks;
    logic [31:0] slot_to_delete;
  } cts_cmd_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] due_handle;
    logic [2:0]  slot;
    logic        last;
  } cts_result_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [31:0] handle;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  runs;
  } cts_entry_t;

  typedef enum logic {
    UNIT_TICK,
    UNIT_CONSUME
  } cts_unit_op_t;

  typedef struct packed {
    cts_entry_t entry;
    logic       due;
  } cts_unit_out_t;

endpackage

// ===== hw/rtl/cts_ram.sv =====
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cts_entry_unit.sv =====
module cts_entry_unit
  import cts_pkg::*;
(
  input  cts_unit_op_t  op,
  input  cts_entry_t    entry,
  output cts_unit_out_t res
);

  always_comb begin
    res.entry = entry;
    res.due   = (entry.runs != 8'd0);
    case (op)
      UNIT_TICK: begin
        if (entry.delay != 32'd0) begin
          res.entry.delay = entry.delay - 32'd1;
        end else begin
          res.entry.delay = entry.period;
          res.entry.runs  = entry.runs + 8'd1;
        end
      end
      UNIT_CONSUME: begin
        if (entry.runs != 8'd0) begin
          res.entry.runs = entry.runs - 8'd1;
        end
      end
      default: begin
        res.entry = entry;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cooperative_task_scheduler_top.sv =====
// Channel   Signals               Transfer
// --------  --------------------  ------------------------------------------
// command   start, busy, cmd      rising edge with start high and busy low
// result    strobe, result        every cycle strobe is high (no back-pressure)
//
// Init, add, an out-of-range delete, and tick or dispatch on an empty table answer
// in the cycle after the transfer, busy staying low. Tick, dispatch and delete walk
// the table (dispatch ends in an extra result state, delete checks the handle first);
// each entry takes a RAM read step and an update/write-back step.
// Reset (rst, synchronous) empties the table. Unknown commands give no result.
// The receiver cannot stall; busy falls together with the final strobe.
module cooperative_task_scheduler_top
  import cts_pkg::*;
#(
  parameter int MAX_TASKS = CTS_MAX_TASKS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cts_cmd_t    cmd,
  output logic        strobe,
  output cts_result_t result
);

  localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W   = $clog2(MAX_TASKS + 1);
  localparam int FOUND_W = $clog2(CTS_RESULT_LIMIT + 1);
  localparam int ENTRY_W = $bits(cts_entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_RD,
    S_TICK_WR,
    S_DISP_RD,
    S_DISP_WR,
    S_DISP_END,
    S_DEL_RD,
    S_DEL_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   used;        // entries in use
  logic [CNT_W-1:0]   idx;         // current walk position
  logic [2:0]         del_slot;    // low bits of the slot being deleted
  logic [FOUND_W-1:0] found;       // due entries seen in this dispatch
  logic               held_valid;  // due result held back to learn "last"
  logic [31:0]        held_handle;
  logic [2:0]         held_slot;

  // RAM and entry unit hookup
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  cts_entry_t       ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  cts_entry_t       ram_rdata;
  cts_unit_op_t     unit_op;
  cts_unit_out_t    unit_out;

  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W:0]   idx_inc2;
  logic             walk_end;
  logic             add_ok;

  assign ram_rdata = cts_entry_t'(ram_rdata_raw);
  assign idx_inc   = idx + CNT_W'(1);
  assign idx_inc2  = {1'b0, idx} + (CNT_W + 1)'(2);
  assign walk_end  = (idx_inc == used);
  assign add_ok    = (used != CNT_W'(MAX_TASKS));

  function automatic cts_result_t make_result(logic [2:0] kind, logic [31:0] handle,
                                              logic [2:0] slot_bits, logic is_last);
    cts_result_t r;
    r.result_kind = kind;
    r.due_handle  = handle;
    r.slot        = slot_bits;
    r.last        = is_last;
    return r;
  endfunction

  cts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  cts_entry_unit u_unit (
    .op    (unit_op),
    .entry (ram_rdata),
    .res   (unit_out)
  );

  // RAM port steering per sequencer state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[IDX_W-1:0];
    ram_wdata = unit_out.entry;
    ram_raddr = idx[IDX_W-1:0];
    unit_op   = UNIT_TICK;
    case (state)
      S_IDLE: begin
        // add writes the new entry straight from the command
        ram_waddr        = used[IDX_W-1:0];
        ram_wdata.handle = cmd.task_handle;
        ram_wdata.delay  = cmd.delay_ticks;
        ram_wdata.period = cmd.period_ticks;
        ram_wdata.runs   = 8'd0;
        ram_we           = start && (cmd.command == CMD_ADD) && add_ok;
      end
      S_TICK_WR: begin
        unit_op = UNIT_TICK;
        ram_we  = 1'b1;
      end
      S_DISP_WR: begin
        unit_op = UNIT_CONSUME;
        ram_we  = unit_out.due;
      end
      S_SHIFT_RD: begin
        ram_raddr = idx_inc[IDX_W-1:0];
      end
      S_SHIFT_WR: begin
        ram_wdata = ram_rdata;
        ram_we    = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      busy       <= 1'b0;
      strobe     <= 1'b0;
      used       <= '0;
      held_valid <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd.command)
              CMD_INIT: begin
                used   <= '0;
                strobe <= 1'b1;
                result <= make_result(KIND_INIT_DONE, 32'd0, 3'd0, 1'b1);
              end
              CMD_ADD: begin
                strobe <= 1'b1;
                if (add_ok) begin
                  used   <= used + CNT_W'(1);
                  result <= make_result(KIND_ADDED, 32'd0, 3'(used), 1'b1);
                end else begin
                  result <= make_result(KIND_FULL, 32'd0, 3'd0, 1'b1);
                end
              end
              CMD_TICK: begin
                idx <= '0;
                if (used == '0) begin
                  strobe <= 1'b1;
                  result <= make_result(KIND_TICK_DONE, 32'd0, 3'd0, 1'b1);
                end else begin
                  busy  <= 1'b1;
                  state <= S_TICK_RD;
                end
              end
              CMD_DISPATCH: begin
                idx        <= '0;
                found      <= '0;
                held_valid <= 1'b0;
                if (used == '0) begin
                  strobe <= 1'b1;
                  result <= make_result(KIND_NONE_DUE, 32'd0, 3'd0, 1'b1);
                end else begin
                  busy  <= 1'b1;
                  state <= S_DISP_RD;
                end
              end
              CMD_DELETE: begin
                del_slot <= cmd.slot_to_delete[2:0];
                if (cmd.slot_to_delete >= 32'(used)) begin
                  strobe <= 1'b1;
                  result <= make_result(KIND_DEL_REJECT, 32'd0,
                                        cmd.slot_to_delete[2:0], 1'b1);
                end else begin
                  idx   <= cmd.slot_to_delete[CNT_W-1:0];
                  busy  <= 1'b1;
                  state <= S_DEL_RD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_TICK_RD: begin
          state <= S_TICK_WR;
        end

        S_TICK_WR: begin
          if (walk_end) begin
            strobe <= 1'b1;
            result <= make_result(KIND_TICK_DONE, 32'd0, 3'd0, 1'b1);
            busy   <= 1'b0;
            state  <= S_IDLE;
          end else begin
            idx   <= idx_inc;
            state <= S_TICK_RD;
          end
        end

        S_DISP_RD: begin
          state <= S_DISP_WR;
        end

        S_DISP_WR: begin
          // the previous due entry is not the final one once another shows up
          if (unit_out.due) begin
            if (held_valid) begin
              strobe <= 1'b1;
              result <= make_result(KIND_DUE, held_handle, held_slot, 1'b0);
            end
            held_valid  <= 1'b1;
            held_handle <= ram_rdata.handle;
            held_slot   <= 3'(idx);
            found       <= found + FOUND_W'(1);
          end
          if (walk_end ||
              (unit_out.due && (found == FOUND_W'(CTS_RESULT_LIMIT - 1)))) begin
            state <= S_DISP_END;
          end else begin
            idx   <= idx_inc;
            state <= S_DISP_RD;
          end
        end

        S_DISP_END: begin
          strobe <= 1'b1;
          if (held_valid) begin
            result <= make_result(KIND_DUE, held_handle, held_slot, 1'b1);
          end else begin
            result <= make_result(KIND_NONE_DUE, 32'd0, 3'd0, 1'b1);
          end
          held_valid <= 1'b0;
          busy       <= 1'b0;
          state      <= S_IDLE;
        end

        S_DEL_RD: begin
          state <= S_DEL_CHK;
        end

        S_DEL_CHK: begin
          if (ram_rdata.handle == 32'd0) begin
            // empty handle: table stays as is
            strobe <= 1'b1;
            result <= make_result(KIND_DEL_REJECT, 32'd0, del_slot, 1'b1);
            busy   <= 1'b0;
            state  <= S_IDLE;
          end else if (walk_end) begin
            used   <= used - CNT_W'(1);
            strobe <= 1'b1;
            result <= make_result(KIND_DELETED, 32'd0, del_slot, 1'b1);
            busy   <= 1'b0;
            state  <= S_IDLE;
          end else begin
            state <= S_SHIFT_RD;
          end
        end

        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end

        S_SHIFT_WR: begin
          // entry idx+1 has just been copied down into idx
          if (idx_inc2 == {1'b0, used}) begin
            used   <= used - CNT_W'(1);
            strobe <= 1'b1;
            result <= make_result(KIND_DELETED, 32'd0, del_slot, 1'b1);
            busy   <= 1'b0;
            state  <= S_IDLE;
          end else begin
            idx   <= idx_inc;
            state <= S_SHIFT_RD;
          end
        end

        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/tb_cooperative_task_scheduler_top.sv =====
`timescale 1ns / 1ps

module tb_cooperative_task_scheduler_top;
  import cts_pkg::*;

  // Cycle budget: ~330 transfers, each with its worst-case busy time plus a gap,
  // still stay far below the limit.
  localparam int CYCLE_LIMIT = 200000;
  // Tail after the last reply: longer than any command's busy time.
  localparam int TAIL_CYCLES = 40;

  // Shadow of the scheduler table. note_command works out the replies that
  // a command transfer produces. check_result holds each reply against the
  // oldest one still outstanding.
  class sched_tracker;
    logic [31:0]  handles [CTS_MAX_TASKS];
    logic [31:0]  delays  [CTS_MAX_TASKS];
    logic [31:0]  periods [CTS_MAX_TASKS];
    logic [7:0]   runs    [CTS_MAX_TASKS];
    int unsigned  used;
    int           errors;
    cts_result_t  pending_replies[$];

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function void push_reply(logic [2:0] kind, logic [31:0] handle, logic [2:0] slot,
                             logic last);
      cts_result_t r;
      r.result_kind = kind;
      r.due_handle  = handle;
      r.slot        = slot;
      r.last        = last;
      pending_replies.push_back(r);
    endfunction

    function void note_command(cts_cmd_t c);
      int unsigned due_total;
      int unsigned emitted;
      int unsigned idx;
      case (c.command)
        CMD_INIT: begin
          used = 0;
          push_reply(KIND_INIT_DONE, '0, '0, 1'b1);
        end
        CMD_ADD: begin
          if (used >= CTS_MAX_TASKS) begin
            push_reply(KIND_FULL, '0, '0, 1'b1);
          end else begin
            handles[used] = c.task_handle;
            delays[used]  = c.delay_ticks;
            periods[used] = c.period_ticks;
            runs[used]    = '0;
            push_reply(KIND_ADDED, '0, 3'(used), 1'b1);
            used++;
          end
        end
        CMD_TICK: begin
          for (int unsigned i = 0; i < used; i++) begin
            if (delays[i] != '0) begin
              delays[i] = delays[i] - 32'd1;
            end else begin
              delays[i] = periods[i];
              runs[i]   = runs[i] + 8'd1;   // wraps at 256
            end
          end
          push_reply(KIND_TICK_DONE, '0, '0, 1'b1);
        end
        CMD_DISPATCH: begin
          // Count first so the final due reply can carry last.
          due_total = 0;
          for (int unsigned i = 0; i < used; i++) begin
            if (runs[i] != '0 && due_total < CTS_RESULT_LIMIT) due_total++;
          end
          if (due_total == 0) begin
            push_reply(KIND_NONE_DUE, '0, '0, 1'b1);
          end else begin
            emitted = 0;
            for (int unsigned i = 0; i < used && emitted < due_total; i++) begin
              if (runs[i] != '0) begin
                runs[i] = runs[i] - 8'd1;
                emitted++;
                push_reply(KIND_DUE, handles[i], 3'(i), emitted == due_total);
              end
            end
          end
        end
        CMD_DELETE: begin
          // Range check first: a slot past the used count is never read.
          if (c.slot_to_delete >= used || handles[c.slot_to_delete[2:0]] == '0) begin
            push_reply(KIND_DEL_REJECT, '0, c.slot_to_delete[2:0], 1'b1);
          end else begin
            idx = c.slot_to_delete;
            for (int unsigned i = idx; i + 1 < used; i++) begin
              handles[i] = handles[i + 1];
              delays[i]  = delays[i + 1];
              periods[i] = periods[i + 1];
              runs[i]    = runs[i + 1];
            end
            used--;
            push_reply(KIND_DELETED, '0, c.slot_to_delete[2:0], 1'b1);
          end
        end
        default: ;  // unknown opcodes: dropped, no reply
      endcase
    endfunction

    function void check_result(cts_result_t got);
      cts_result_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: kind %0d handle %h slot %0d last %0d",
               got.result_kind, got.due_handle, got.slot, got.last);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (got.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
          errors++;
        end
        if (got.due_handle !== want.due_handle) begin
          $error("due_handle: expected %h, got %h", want.due_handle, got.due_handle);
          errors++;
        end
        if (got.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, got.slot);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  cts_cmd_t    cmd;
  logic        strobe;
  cts_result_t result;

  int           cycle_count;
  bit           allow_gaps;
  sched_tracker tracker = new();

  cooperative_task_scheduler_top uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  // 100 MHz clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Cycle counter for the watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake or a missing reply ends here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("cooperative_task_scheduler_top: mismatch");
    $finish;
  end

  // Reply monitor. No back-pressure, so every strobe cycle is a transfer.
  // Sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst && strobe) tracker.check_result(result);
  end

  function automatic cts_cmd_t pack_cmd(logic [2:0] op, logic [31:0] handle,
                                        logic [31:0] delay, logic [31:0] period,
                                        logic [31:0] del_slot);
    cts_cmd_t c;
    c.command        = op;
    c.task_handle    = handle;
    c.delay_ticks    = delay;
    c.period_ticks   = period;
    c.slot_to_delete = del_slot;
    return c;
  endfunction

  // One command transfer. Entered and left at a falling edge.
  // Optional gap first (start low, junk on cmd), then start is held high
  // until a rising edge sees busy low.
  task automatic send_command(cts_cmd_t c);
    int gap;
    gap = 0;
    if (allow_gaps && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      start <= 1'b0;
      cmd   <= pack_cmd(3'($urandom), $urandom, $urandom, $urandom, $urandom);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    tracker.note_command(c);
    @(negedge clk);
  endtask

  // Hold the sender until every predicted reply has come back.
  task automatic wait_for_replies();
    start <= 1'b0;
    @(negedge clk);
    while (tracker.pending_replies.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [2:0]  op;
    logic [31:0] h;
    logic [31:0] d;
    logic [31:0] p;
    logic [31:0] s;
    int          pick;

    rst         = 1'b1;
    start       = 1'b0;
    cmd         = '0;
    cycle_count = 0;
    allow_gaps  = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- Directed part ----
    // Handle 0 entry: accepted on add, refused on delete.
    send_command(pack_cmd(CMD_ADD, '0, '0, '0, '0));
    send_command(pack_cmd(CMD_DELETE, '0, '0, '0, 32'd0));
    // Slot far out of range: refused, slot shows the low bits.
    send_command(pack_cmd(CMD_DELETE, '0, '0, '0, 32'hFFFF_FFFF));
    send_command(pack_cmd(CMD_DISPATCH, '0, '0, '0, '0));
    send_command(pack_cmd(CMD_TICK, '0, '0, '0, '0));
    send_command(pack_cmd(CMD_DISPATCH, '0, '0, '0, '0));
    send_command(pack_cmd(CMD_INIT, '1, '1, '1, '1));
    // Fill the table with extreme handles, delays and periods.
    for (int i = 0; i < CTS_MAX_TASKS; i++) begin
      h = (i == 0) ? 32'hFFFF_FFFF : {4{8'(i * 37 + 1)}};
      d = (i == 1) ? 32'hFFFF_FFFF : 32'(i % 3);
      p = (i == 2) ? 32'hFFFF_FFFF : 32'(i % 2);
      send_command(pack_cmd(CMD_ADD, h, d, p, '0));
    end
    // One more add: table full.
    send_command(pack_cmd(CMD_ADD, 32'h1234_5678, '0, '0, '0));
    send_command(pack_cmd(CMD_TICK, '0, '0, '0, '0));
    send_command(pack_cmd(CMD_TICK, '0, '0, '0, '0));
    send_command(pack_cmd(CMD_DISPATCH, '0, '0, '0, '0));
    // Delete the tail, then the head (everything shifts down).
    send_command(pack_cmd(CMD_DELETE, '0, '0, '0, 32'd7));
    send_command(pack_cmd(CMD_DELETE, '0, '0, '0, 32'd0));
    send_command(pack_cmd(CMD_DELETE, '0, '0, '0, 32'd7));
    // Unknown opcodes: no reply, no state change.
    send_command(pack_cmd(3'd5, '1, '1, '1, '1));
    send_command(pack_cmd(3'd6, '0, '0, '0, '0));
    send_command(pack_cmd(3'd7, '1, '0, '1, '0));
    send_command(pack_cmd(CMD_DISPATCH, '0, '0, '0, '0));

    // Pending-run wrap: 257 ticks on a period-0 entry leave one run.
    wait_for_replies();
    send_command(pack_cmd(CMD_INIT, '0, '0, '0, '0));
    send_command(pack_cmd(CMD_ADD, 32'hA5A5_0001, '0, '0, '0));
    repeat (257) send_command(pack_cmd(CMD_TICK, $urandom, $urandom, $urandom, $urandom));
    send_command(pack_cmd(CMD_DISPATCH, '0, '0, '0, '0));
    send_command(pack_cmd(CMD_DISPATCH, '0, '0, '0, '0));

    // ---- Random part ----
    // Mostly adds/ticks/dispatches with short delays so runs pile up and
    // dispatches report several entries; deletes aim mostly at live slots.
    for (int k = 0; k < 40; k++) begin
      allow_gaps = !(k >= 10 && k < 30);   // back-to-back stretch
      if (k == 30) wait_for_replies();
      pick = $urandom_range(0, 99);
      h = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
      d = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 6));
      p = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 4));
      case ($urandom_range(0, 6))
        0:       s = $urandom;
        1:       s = 32'($urandom_range(0, 15));
        default: s = 32'($urandom_range(0, tracker.used));
      endcase
      if (pick < 3)       op = CMD_INIT;
      else if (pick < 28) op = CMD_ADD;
      else if (pick < 55) op = CMD_TICK;
      else if (pick < 78) op = CMD_DISPATCH;
      else if (pick < 96) op = CMD_DELETE;
      else                op = 3'($urandom_range(5, 7));
      send_command(pack_cmd(op, h, d, p, s));
    end

    // ---- Wind-down ----
    wait_for_replies();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending_replies.size() == 0) begin
      $display("cooperative_task_scheduler_top: match");
    end else begin
      $display("cooperative_task_scheduler_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cts_pkg.sv
hw/rtl/cts_ram.sv
hw/rtl/cts_entry_unit.sv
hw/rtl/cooperative_task_scheduler_top.sv
dv/tb_cooperative_task_scheduler_top.sv
